@@ src/discrete_inverse_cdf_sampler_core_macros.svh @@
// Assertion macros for the discrete inverse-CDF sampler.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef DISCRETE_INVERSE_CDF_SAMPLER_CORE_MACROS_SVH
`define DISCRETE_INVERSE_CDF_SAMPLER_CORE_MACROS_SVH

// prop must hold at every clock edge out of reset
`define DICS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// cond must never be seen out of reset
`define DICS_NEVER(label, cond, msg) \
    `DICS_ASSERT(label, !(cond), msg)

`endif

@@ src/dics_pkg.sv @@
// Shared constants, types and helpers for the discrete inverse-CDF sampler.
// No dependencies; used by every module of the block.
package dics_pkg;

    localparam int MAX_LAYERS    = 64;
    localparam int WEIGHT_BITS   = 16;
    localparam int FRACTION_BITS = 32;

    localparam int ENERGY_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int U_IN_W   = 32;
    localparam int CHOSEN_W = 6;
    localparam int STATUS_W = 3;

    localparam int IDX_W  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int LC_W   = $clog2(MAX_LAYERS + 1);
    localparam int CUM_W  = WEIGHT_BITS + ((MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 0);
    localparam int THR_W  = CUM_W + 1;
    localparam int PROD_W = FRACTION_BITS + CUM_W;

    // cells evaluated per clock in the search chain
    localparam int GRP     = 8;
    localparam int NUM_GRP = (MAX_LAYERS + GRP - 1) / GRP;
    localparam int GCNT_W  = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;

    localparam logic [63:0] WMAX_64 = (64'd1 << WEIGHT_BITS) - 64'd1;

    localparam logic [STATUS_W-1:0] ST_SAMPLED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO_ENERGY = 3'd5;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // search token handed from cell to cell
    typedef struct packed {
        logic                found;
        logic [ENERGY_W-1:0] energy;
        logic [IDX_W-1:0]    idx;
    } t_link;

    typedef struct packed {
        logic mul_en;
        logic thr_en;
    } t_scale_ctl;

    function automatic logic [WEIGHT_BITS-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
        logic [63:0] w64;
        w64 = 64'(w);
        if (w64 > WMAX_64) begin
            return WEIGHT_BITS'(WMAX_64);
        end
        return WEIGHT_BITS'(w64);
    endfunction

endpackage

@@ src/dics_scale.sv @@
// Threshold unit: product u * total, then ceil(product / 2^FRACTION_BITS).
// Depends on dics_pkg.
module dics_scale import dics_pkg::*; (
    input  logic                     i_clk,
    input  t_scale_ctl               i_ctl,
    input  logic [FRACTION_BITS-1:0] i_u,
    input  logic [CUM_W-1:0]         i_total,
    output logic [THR_W-1:0]         o_thr
);

    logic [PROD_W-1:0] r_prod;
    logic [THR_W-1:0]  r_thr;

    // cum * 2^F >= P  <=>  cum >= ceil(P / 2^F)
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(i_u) * PROD_W'(i_total);
        end
        if (i_ctl.thr_en) begin
            r_thr <= THR_W'(r_prod[PROD_W-1:FRACTION_BITS])
                   + THR_W'(|r_prod[FRACTION_BITS-1:0]);
        end
    end

    assign o_thr = r_thr;

endmodule

@@ src/dics_cell.sv @@
// One table cell: holds a layer's energy and running weight, and passes the
// search token on, claiming it when it is the first cell to reach the threshold.
// Depends on dics_pkg.
module dics_cell import dics_pkg::*; (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [ENERGY_W-1:0] i_energy,
    input  logic [CUM_W-1:0]    i_cum,
    input  logic [IDX_W-1:0]    i_index,
    input  logic [LC_W-1:0]     i_count,
    input  logic [THR_W-1:0]    i_thr,
    input  t_link               i_link,
    output t_link               o_link
);

    logic [ENERGY_W-1:0] r_energy;
    logic [CUM_W-1:0]    r_cum;
    logic                hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_energy <= i_energy;
            r_cum    <= i_cum;
        end
    end

    assign hit = (LC_W'(i_index) < i_count) && ({1'b0, r_cum} >= i_thr);

    always_comb begin
        o_link = i_link;
        if (!i_link.found && hit) begin
            o_link.found  = 1'b1;
            o_link.energy = r_energy;
            o_link.idx    = i_index;
        end
    end

endmodule

@@ src/discrete_inverse_cdf_sampler_core.sv @@
// Discrete inverse-CDF sampler. A load transaction answers on the cycle after
// it is taken, as does a sample that fails on an empty table or zero total
// weight. A good sample takes one multiply, one threshold, then the search
// token walks the cell chain eight cells per clock. busy is high for the
// whole sample; the result strobe o_valid lasts one cycle and cannot be held
// off, so the receiver must take it then. No clearing pass follows reset.
module discrete_inverse_cdf_sampler_core import dics_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_opcode,
    input  logic                i_restart_table,
    input  logic [ENERGY_W-1:0] i_layer_energy_in,
    input  logic [WEIGHT_W-1:0] i_layer_weight_in,
    input  logic [U_IN_W-1:0]   i_uniform_fraction,
    output logic                o_valid,
    output logic [ENERGY_W-1:0] o_energy_out,
    output logic [CHOSEN_W-1:0] o_chosen_layer,
    output logic [STATUS_W-1:0] o_status
);

    `include "discrete_inverse_cdf_sampler_core_macros.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_THR    = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [LC_W-1:0]          r_count, n_count;
    logic [CUM_W-1:0]         r_total, n_total;
    logic [ENERGY_W-1:0]      r_last_energy, n_last_energy;
    logic [FRACTION_BITS-1:0] r_u, n_u;
    logic [GCNT_W-1:0]        r_grp, n_grp;
    logic                     r_valid, n_valid;
    logic [ENERGY_W-1:0]      r_energy_out, n_energy_out;
    logic [CHOSEN_W-1:0]      r_chosen, n_chosen;
    logic [STATUS_W-1:0]      r_status, n_status;

    logic                     accept;
    logic [LC_W-1:0]          cnt_eff;
    logic                     load_ok;
    logic [CUM_W-1:0]         new_cum;
    logic [THR_W-1:0]         thr;
    t_scale_ctl               scale_ctl;
    t_link                    cell_in  [MAX_LAYERS];
    t_link                    cell_out [MAX_LAYERS];
    t_link                    r_link   [NUM_GRP];

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign cnt_eff = i_restart_table ? '0 : r_count;
    assign load_ok = accept && (i_opcode == OP_LOAD) && (i_layer_energy_in != '0)
                   && (cnt_eff < LC_W'(MAX_LAYERS));
    assign new_cum = ((cnt_eff == '0) ? '0 : r_total)
                   + CUM_W'(sat_weight(i_layer_weight_in));

    assign scale_ctl.mul_en = (r_state == S_MUL);
    assign scale_ctl.thr_en = (r_state == S_THR);

    dics_scale u_scale (
        .i_clk   (i_clk),
        .i_ctl   (scale_ctl),
        .i_u     (r_u),
        .i_total (r_total),
        .o_thr   (thr)
    );

    // cell chain; a register stage closes every group of GRP cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_LAYERS; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign cell_in[gi] = '0;
            end else if ((gi % GRP) == 0) begin : g_seg
                assign cell_in[gi] = r_link[gi / GRP - 1];
            end else begin : g_mid
                assign cell_in[gi] = cell_out[gi - 1];
            end

            dics_cell u_cell (
                .i_clk    (i_clk),
                .i_wr_en  (load_ok && (cnt_eff[IDX_W-1:0] == IDX_W'(gi))),
                .i_energy (i_layer_energy_in),
                .i_cum    (new_cum),
                .i_index  (IDX_W'(gi)),
                .i_count  (r_count),
                .i_thr    (thr),
                .i_link   (cell_in[gi]),
                .o_link   (cell_out[gi])
            );
        end

        for (gi = 0; gi < NUM_GRP; gi++) begin : g_seg_reg
            localparam int LAST = ((gi * GRP + GRP - 1) < MAX_LAYERS) ?
                                  (gi * GRP + GRP - 1) : (MAX_LAYERS - 1);
            always_ff @(posedge i_clk) begin
                r_link[gi] <= cell_out[LAST];
            end
        end
    endgenerate

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_total       = r_total;
        n_last_energy = r_last_energy;
        n_u           = r_u;
        n_grp         = r_grp;
        n_valid       = 1'b0;
        n_energy_out  = '0;
        n_chosen      = '0;
        n_status      = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_LOAD) begin
                        n_valid = 1'b1;
                        n_count = cnt_eff;
                        if (i_layer_energy_in == '0) begin
                            n_status = ST_ZERO_ENERGY;
                        end else if (!load_ok) begin
                            n_status = ST_FULL;
                        end else begin
                            n_count       = cnt_eff + LC_W'(1);
                            n_total       = new_cum;
                            n_last_energy = i_layer_energy_in;
                            n_energy_out  = i_layer_energy_in;
                            n_chosen      = CHOSEN_W'(cnt_eff);
                            n_status      = ST_ACCEPTED;
                        end
                    end else if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_EMPTY;
                    end else if (r_total == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_ZERO_TOTAL;
                    end else begin
                        n_u     = FRACTION_BITS'(i_uniform_fraction);
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_THR;
            end
            S_THR: begin
                n_grp   = '0;
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                n_grp = r_grp + GCNT_W'(1);
                if (r_grp == GCNT_W'(NUM_GRP - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_valid  = 1'b1;
                n_status = ST_SAMPLED;
                if (r_link[NUM_GRP-1].found) begin
                    n_energy_out = r_link[NUM_GRP-1].energy;
                    n_chosen     = CHOSEN_W'(r_link[NUM_GRP-1].idx);
                end else begin
                    // clamp to the last layer
                    n_energy_out = r_last_energy;
                    n_chosen     = CHOSEN_W'(r_count - LC_W'(1));
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_grp    <= '0;
            r_status <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_valid  <= n_valid;
            r_grp    <= n_grp;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total       <= n_total;
        r_last_energy <= n_last_energy;
        r_u           <= n_u;
        r_energy_out  <= n_energy_out;
        r_chosen      <= n_chosen;
    end

    assign o_valid        = r_valid;
    assign o_energy_out   = r_energy_out;
    assign o_chosen_layer = r_chosen;
    assign o_status       = r_status;

    `DICS_ASSERT(a_accept_answered, accept |=> (o_valid || busy),
        "accepted transaction neither answered nor in progress")
    `DICS_NEVER(a_count_bound, r_count > LC_W'(MAX_LAYERS),
        "layer count beyond table depth")
    `DICS_ASSERT(a_count_held, (busy && $past(busy)) |-> $stable(r_count),
        "layer count changed during a sample")
    `DICS_ASSERT(a_sample_from_done, (o_valid && (o_status == ST_SAMPLED)) |->
        ($past(r_state) == S_DONE), "sample result without a finished search")

endmodule
